### rtl/sorted_set_store_macros.svh
// Assertion helpers for the sorted set store. Each property is sampled on
// the rising edge of clk and is switched off while rst_n is low.
`ifndef SORTED_SET_STORE_MACROS_SVH
`define SORTED_SET_STORE_MACROS_SVH

// Same-cycle implication.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int Depth       = 64;
    localparam int KeyWidth    = 32;
    localparam int IdxW        = $clog2(Depth);
    localparam int CntW        = $clog2(Depth + 1);
    localparam int OpW         = 2;
    localparam int ValueW      = 32;
    localparam int CountFieldW = 7;

    typedef enum logic [OpW-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_CMP,
        S_CHECK,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                   found;
        logic                   full_reject;
        logic [CountFieldW-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic                wr_en;
        logic [IdxW-1:0]     wr_addr;
        logic [KeyWidth-1:0] wr_data;
        logic                rd_en;
        logic [IdxW-1:0]     rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/sss_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one set operation per transaction.
interface sss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: one result per transaction.
interface sss_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic       full_reject;
    logic [6:0] entry_count;

    modport source (output valid, output found, output full_reject,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input full_reject,
                    input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/sss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module sss_ram #(
    parameter int Width = 32,
    parameter int Depth = 64,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [Width-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/sss_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: binary search over the RAM, then a shift of the tail one entry
// per cycle for insert and delete.
module sss_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    sss_req_if.sink                    req,
    output sss_pkg::ram_req_t          ram,
    input  logic [sss_pkg::KeyWidth-1:0] rd_data,
    output logic                       res_valid,
    output sss_pkg::result_t           res,
    input  logic                       res_take
);
    import sss_pkg::*;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [KeyWidth-1:0] key_reg, key_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic [CntW-1:0]     lo_reg, lo_next;
    logic [CntW-1:0]     hi_reg, hi_next;
    logic [IdxW-1:0]     mid_reg, mid_next;
    logic [CntW-1:0]     moves_reg, moves_next;
    logic [IdxW-1:0]     src_reg, src_next;
    logic                pend_reg, pend_next;
    logic [IdxW-1:0]     dst_reg, dst_next;
    logic                found_reg, found_next;
    logic                reject_reg, reject_next;
    logic [CntW:0]       mid_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        moves_reg  <= moves_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        found_reg  <= found_next;
        reject_reg <= reject_next;
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        moves_next  = moves_reg;
        src_next    = src_reg;
        pend_next   = pend_reg;
        dst_next    = dst_reg;
        found_next  = found_reg;
        reject_next = reject_reg;
        req.ready   = 1'b0;
        ram         = '0;
        res_valid   = 1'b0;
        res.found       = found_reg;
        res.full_reject = reject_reg;
        res.entry_count = CountFieldW'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next     = op_t'(req.operation);
                    key_next    = req.value[KeyWidth-1:0];
                    lo_next     = '0;
                    hi_next     = count_reg;
                    found_next  = 1'b0;
                    reject_next = 1'b0;
                    pend_next   = 1'b0;
                    unique case (req.operation)
                        OP_INSERT:
                        begin
                            if (count_reg >= CntW'(Depth))
                            begin
                                reject_next = 1'b1;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_DELETE, OP_LOOKUP:
                        begin
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = mid_sum[IdxW:1];
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = mid_sum[IdxW:1];
                    state_next  = S_SEARCH_CMP;
                end
                else if (op_reg == OP_INSERT)
                begin
                    // The store is not full here, so count - 1 fits an index.
                    moves_next = count_reg - lo_reg;
                    src_next   = IdxW'(count_reg - CntW'(1));
                    state_next = S_SHIFT;
                end
                else if (lo_reg < count_reg)
                begin
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = lo_reg[IdxW-1:0];
                    state_next  = S_CHECK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SEARCH_CMP:
            begin
                if (rd_data < key_reg)
                begin
                    lo_next = CntW'({1'b0, mid_reg} + (IdxW + 1)'(1));
                end
                else
                begin
                    hi_next = CntW'(mid_reg);
                end
                state_next = S_SEARCH;
            end

            S_CHECK:
            begin
                if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    if (op_reg == OP_DELETE)
                    begin
                        moves_next = count_reg - lo_reg - CntW'(1);
                        src_next   = IdxW'(lo_reg + CntW'(1));
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SHIFT:
            begin
                // The entry read last cycle lands one place over.
                if (pend_reg)
                begin
                    ram.wr_en   = 1'b1;
                    ram.wr_addr = dst_reg;
                    ram.wr_data = rd_data;
                    pend_next   = 1'b0;
                end
                if (moves_reg != '0)
                begin
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = src_reg;
                    pend_next   = 1'b1;
                    moves_next  = moves_reg - CntW'(1);
                    if (op_reg == OP_INSERT)
                    begin
                        dst_next = src_reg + IdxW'(1);
                        src_next = src_reg - IdxW'(1);
                    end
                    else
                    begin
                        dst_next = src_reg - IdxW'(1);
                        src_next = src_reg + IdxW'(1);
                    end
                end
                else if (!pend_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        ram.wr_en   = 1'b1;
                        ram.wr_addr = lo_reg[IdxW-1:0];
                        ram.wr_data = key_reg;
                        count_next  = count_reg + CntW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CntW'(1);
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sorted_set_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted set store: keeps up to 64 unsigned 32-bit keys in ascending order,
// duplicates included, in a single 64-entry RAM.
//
// The req channel takes one transaction per operation (insert, delete or
// lookup of one key); the rsp channel returns exactly one transaction per
// request with found, full_reject and the entry count after the operation.
// Both are valid/ready channels; a transaction moves when both are high.
//
// Items are handled one at a time. With n stored keys the binary search
// makes at most k = ceil(log2(n+1)) probes, each a RAM read in S_SEARCH
// and a compare in S_SEARCH_CMP because of the RAM's registered read.
// Lookup and delete then read the candidate in S_CHECK. Insert and a
// found delete shift the tail one entry per cycle through the single
// write port.
//
// Reset clears the entry count and the control state; the RAM contents are
// not cleared, since no entry at or above the count is ever read.
// A finished result sits in the output register; the next request is taken
// while it waits, and the engine holds its following result until the
// receiver has taken the earlier one.
module sorted_set_store (
    input  logic      clk,
    input  logic      rst_n,
    sss_req_if.sink   req,
    sss_rsp_if.source rsp
);
    import sss_pkg::*;

    ram_req_t            ram;
    logic [KeyWidth-1:0] rd_data;
    logic                res_valid;
    result_t             res;
    logic                res_take;
    logic                rsp_valid_reg, rsp_valid_next;
    result_t             rsp_data_reg;

    sss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram       (ram),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    sss_ram #(
        .Width (KeyWidth),
        .Depth (Depth)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (rd_data)
    );

    // The output register can load when it is empty or being emptied.
    assign res_take = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_data_reg.found;
    assign rsp.full_reject = rsp_data_reg.full_reject;
    assign rsp.entry_count = rsp_data_reg.entry_count;

endmodule

`default_nettype wire

### rtl/sss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_set_store_macros.svh"

module sss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_found,
    input logic       rsp_full_reject,
    input logic [6:0] rsp_entry_count
);
    import sss_pkg::*;

    // A waiting result stays offered until it is taken.
    `SSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

    // The store never reports more keys than it can hold.
    `SSS_ASSERT_NOW(a_count_range, rsp_valid, rsp_entry_count <= 7'(Depth), "entry count above depth")

    // A dropped insert never also reports a hit.
    `SSS_ASSERT_NOW(a_reject_excl, rsp_valid, !(rsp_found && rsp_full_reject), "found with full_reject")

    // Requests are taken one at a time: no request is accepted twice in a row.
    `SSS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "back-to-back request accept")

endmodule

bind sorted_set_store sss_checker u_sss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_full_reject (rsp.full_reject),
    .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

### tb/tb_sorted_set_store.sv
`timescale 1ns / 1ps

// Testbench for the sorted set store.
//
// Requests are driven on the req channel and every accepted transaction is
// applied to a shadow copy of the store kept inside this module. The copy is
// a plain ascending array with a count, and applying an operation to it
// yields the response that the block must produce. That response is queued.
// A separate monitor pops the oldest queued response whenever a response
// transaction is accepted and compares it field by field.
//
// The sender works in bursts with random gaps between them. The receiver
// switches among its own stall patterns: always ready, coin flip, sparse and
// periodic. Together they idle the engine between requests and hold it in
// S_FINISH behind a full output register. A watchdog ends the run if no
// transaction of either channel moves for a long stretch.
module tb_sorted_set_store;
    import sss_pkg::*;

    // Operation code 3 is not a defined operation; the block must treat it
    // as a no-op that still returns a response.
    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

    // Longest legal silence on both channels: the engine's worst-case work
    // plus sender gaps and receiver stalls, taken many times over.
    localparam int IDLE_LIMIT  = 2000;
    // Cycles to watch after the last response for stray transactions.
    localparam int TAIL_CYCLES = 100;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    sss_req_if req_ch ();
    sss_rsp_if rsp_ch ();

    sorted_set_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the store. Only positions below shadow_count hold keys.
    logic [KeyWidth-1:0] shadow_keys [0:Depth-1];
    int                  shadow_count = 0;

    // Responses still owed by the block, oldest first.
    result_t pending_results [$];
    int      failures = 0;

    // Sender burst state. The test tasks set sender_max_gap; zero gives
    // stretches with a request offered on every cycle.
    int burst_left     = 0;
    int sender_max_gap = 2;

    sink_mode_t sink_mode;
    int         sink_mode_left;
    int         sink_phase;
    int         idle_cycles;

    // Apply one operation to the shadow store and return its response.
    function automatic result_t apply_set_op(input logic [OpW-1:0] op,
                                             input logic [KeyWidth-1:0] key);
        result_t rsp;
        int      pos;
        int      i;
        rsp = '0;
        // First position whose key is not less than the requested one.
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key)
            pos++;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= Depth)
                begin
                    rsp.full_reject = 1'b1;
                end
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i - 1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                end
            end
            OP_DELETE:
            begin
                if (pos < shadow_count && shadow_keys[pos] == key)
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i + 1];
                    shadow_count--;
                    rsp.found = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (pos < shadow_count && shadow_keys[pos] == key)
                    rsp.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        rsp.entry_count = CountFieldW'(shadow_count);
        return rsp;
    endfunction

    // Keys lean toward stored ones and their neighbors so that lookups and
    // deletes hit often and duplicates pile up, with full-range keys mixed in.
    function automatic logic [KeyWidth-1:0] pick_key();
        int                  sel;
        logic [KeyWidth-1:0] key;
        sel = $urandom_range(0, 99);
        if (shadow_count > 0 && sel < 40)
        begin
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
        end
        else if (shadow_count > 0 && sel < 50)
        begin
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
            key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
        end
        else if (sel < 70)
        begin
            key = $urandom_range(0, 15);
        end
        else if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0: key = 32'h0000_0000;
                1: key = 32'hFFFF_FFFF;
                2: key = 32'h8000_0000;
                default: key = 32'h7FFF_FFFF;
            endcase
        end
        else
        begin
            key = $urandom;
        end
        return key;
    endfunction

    // A small share of unused codes is always mixed in as noise.
    function automatic logic [OpW-1:0] pick_op(input int insert_pct,
                                               input int delete_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return OP_UNUSED;
        else if (sel < 3 + insert_pct)
            return OP_INSERT;
        else if (sel < 3 + insert_pct + delete_pct)
            return OP_DELETE;
        else
            return OP_LOOKUP;
    endfunction

    // Offer one request and hold it until the block takes the transaction.
    // At the start of a burst the sender may first idle for a random gap.
    // The response is predicted at the edge where the transaction moves.
    task automatic send_request(input logic [OpW-1:0] op,
                                input logic [KeyWidth-1:0] key);
        int      gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= key;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = apply_set_op(op, key);
        pending_results = {pending_results, predicted};
    endtask

    // Operations on an empty store, including the unused code.
    task automatic test_empty_store();
        sender_max_gap = 2;
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_DELETE, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'hA5A5_A5A5);
    endtask

    // Extreme keys, duplicate copies, hits and misses, and deletes that
    // remove one copy at a time until the key is gone.
    task automatic test_extremes_and_duplicates();
        sender_max_gap = 3;
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'h8000_0000);
        send_request(OP_LOOKUP, 32'h0000_0001);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h8000_0000);
        send_request(OP_DELETE, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h7FFF_FFFF);
    endtask

    // Balanced random operations at a moderate fill level.
    task automatic test_random_mix(input int count);
        sender_max_gap = 4;
        repeat (count)
            send_request(pick_op(35, 30), pick_key());
    endtask

    // Fill the store to capacity, then keep pushing inserts so that the
    // full-store rejection is hit repeatedly while other operations mix in.
    task automatic test_fill_and_overflow();
        sender_max_gap = 3;
        while (shadow_count < Depth)
            send_request(OP_INSERT, pick_key());
        repeat (40)
            send_request(pick_op(55, 10), pick_key());
    endtask

    // Empty the store, mostly by deleting stored keys.
    task automatic test_drain();
        sender_max_gap = 0;
        while (shadow_count > 0)
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(pick_op(0, 50), pick_key());
            else
                send_request(OP_DELETE, shadow_keys[$urandom_range(0, shadow_count - 1)]);
        end
    endtask

    // Phases that lean toward filling, draining or neither, so the count
    // sweeps its whole range, with the sender's gap size changing per phase.
    task automatic test_churn(input int phases, input int per_phase);
        int bias;
        repeat (phases)
        begin
            bias = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0: sender_max_gap = 0;
                1: sender_max_gap = 2;
                default: sender_max_gap = 6;
            endcase
            repeat (per_phase)
            begin
                if (bias == 0)
                    send_request(pick_op(70, 15), pick_key());
                else if (bias == 1)
                    send_request(pick_op(15, 70), pick_key());
                else
                    send_request(pick_op(35, 35), pick_key());
            end
        end
    endtask

    // Receiver: picks a stall pattern, keeps it for a while, then moves on.
    initial
    begin
        rsp_ch.ready   <= 1'b0;
        sink_mode      = SINK_ALWAYS;
        sink_mode_left = 0;
        sink_phase     = 0;
        forever
        begin
            @(posedge clk);
            if (sink_mode_left == 0)
            begin
                sink_mode      = sink_mode_t'($urandom_range(0, 3));
                sink_mode_left = $urandom_range(50, 400);
            end
            sink_mode_left--;
            sink_phase = (sink_phase + 1) % 7;
            case (sink_mode)
                SINK_ALWAYS: rsp_ch.ready <= 1'b1;
                SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     rsp_ch.ready <= (sink_phase >= 3);
            endcase
        end
    end

    // Response monitor. Signals are read right after the edge, so they hold
    // the values that the edge itself saw.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.found !== want.found)
                begin
                    $error("found mismatch: expected %0b, actual %0b",
                           want.found, rsp_ch.found);
                    failures++;
                end
                if (rsp_ch.full_reject !== want.full_reject)
                begin
                    $error("full_reject mismatch: expected %0b, actual %0b",
                           want.full_reject, rsp_ch.full_reject);
                    failures++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.entry_count, rsp_ch.entry_count);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles in which no transaction moves on either
    // channel means the block has hung.
    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sorted_set_store test failed");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_INSERT;
        req_ch.value     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_extremes_and_duplicates();
        test_random_mix(400);
        test_fill_and_overflow();
        test_drain();
        test_churn(5, 140);

        req_ch.valid <= 1'b0;
        // Wait for every owed response, then watch a while for extras.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("sorted_set_store test passed");
        else
            $display("sorted_set_store test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sss_ram.sv
rtl/sss_engine.sv
rtl/sorted_set_store.sv
rtl/sss_checker.sv
tb/tb_sorted_set_store.sv
